FILE: rtl/trsc_pkg.sv
`default_nettype none
package trsc_pkg;

	localparam int THREAD_ID_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int INDEX_W = 32;
	localparam int ID_W = 16;
	localparam int TS_W = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REPORT_DUP = 2'd0,
		CFG_REPORT_OOO = 2'd1,
		CFG_START_INDEX = 2'd2,
		CFG_END_INDEX = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		KIND_TYPED = 3'd0,
		KIND_META_PAYLOAD = 3'd1,
		KIND_META_HEADER = 3'd2,
		KIND_DUMP_HEADER = 3'd3,
		KIND_CHUNK = 3'd4,
		KIND_FILE_HEADER = 3'd5,
		KIND_EOF = 3'd6,
		KIND_OTHER = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		EV_DUP = 4'd0,
		EV_OOO = 4'd1,
		EV_CHUNK_END = 4'd2,
		EV_META_END = 4'd3,
		EV_META_START = 4'd4,
		EV_DUMP = 4'd5,
		EV_CHUNK = 4'd6,
		EV_FILE_START = 4'd7,
		EV_EOF = 4'd8,
		EV_UNKNOWN = 4'd9
	} event_t;

	typedef struct packed {
		logic report_dup;
		logic report_ooo;
	} flags_t;

	// One classified record on its way from the front to the back.
	typedef struct packed {
		logic typed;
		logic [INDEX_W-1:0] idx;
		logic [ID_W-1:0] tid;
		logic [ID_W-1:0] pid;
		logic [TS_W-1:0] ts;
		logic has_close;
		logic [INDEX_W-1:0] close_cnt;
		logic has_main;
		event_t main_code;
		logic [INDEX_W-1:0] main_cnt;
	} work_t;

	// All words caused by one record: an optional chunk end, then an optional event of its own.
	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [ID_W-1:0] thread;
		logic [ID_W-1:0] pid;
		logic [TS_W-1:0] ts;
		logic has_close;
		logic [INDEX_W-1:0] close_cnt;
		logic has_main;
		event_t main_code;
		logic [TS_W-1:0] pts;
		logic [INDEX_W-1:0] pidx;
		logic [INDEX_W-1:0] main_cnt;
	} bundle_t;

	localparam int WORK_W = $bits(work_t);
	localparam int BUNDLE_W = $bits(bundle_t);
	localparam int ENTRY_W = TS_W + INDEX_W;

	function automatic event_t kind_event(input kind_t kind);
		event_t ev;
		case (kind)
			KIND_DUMP_HEADER: ev = EV_DUMP;
			KIND_CHUNK: ev = EV_CHUNK;
			KIND_FILE_HEADER: ev = EV_FILE_START;
			KIND_EOF: ev = EV_EOF;
			KIND_META_PAYLOAD: ev = EV_META_END;
			KIND_META_HEADER: ev = EV_META_START;
			default: ev = EV_UNKNOWN;
		endcase
		return ev;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/trsc_if.sv
`default_nettype none
interface trsc_rec_if;
	logic valid;
	logic ready;
	logic [2:0] record_kind;
	logic first_fragment;
	logic last_fragment;
	logic [15:0] thread_id;
	logic [15:0] process_id;
	logic [63:0] timestamp;

	modport source(output valid, record_kind, first_fragment, last_fragment, thread_id,
		process_id, timestamp, input ready);
	modport sink(input valid, record_kind, first_fragment, last_fragment, thread_id,
		process_id, timestamp, output ready);
endinterface

interface trsc_evt_if;
	logic valid;
	logic ready;
	logic [3:0] event_res;
	logic [31:0] record_index;
	logic [15:0] event_thread;
	logic [15:0] event_process;
	logic [63:0] event_timestamp;
	logic [63:0] previous_timestamp;
	logic [31:0] previous_index;
	logic [31:0] run_count;
	logic last_of_run;

	modport source(output valid, event_res, record_index, event_thread, event_process,
		event_timestamp, previous_timestamp, previous_index, run_count, last_of_run,
		input ready);
	modport sink(input valid, event_res, record_index, event_thread, event_process,
		event_timestamp, previous_timestamp, previous_index, run_count, last_of_run,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/trace_record_stream_checker.sv
// An accepted record's words pass through the queue, the table stage and the output buffer.
// One record per cycle while the queue has room and no clear runs; two words go out in turn.
// The thread table is one read and one write per cycle, with the last write forwarded.
// After reset the table is cleared one entry a cycle, all 2**THREAD_ID_BITS entries, while
// records stay stalled; configuration writes are taken throughout.
`default_nettype none
module trace_record_stream_checker import trsc_pkg::*; #(
	parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	trsc_rec_if.sink records,
	trsc_evt_if.source events,
	input wire logic wr_en,
	input wire logic [CFG_INDEX_W-1:0] wr_index,
	input wire logic [CFG_DATA_W-1:0] wr_data
);

	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	flags_t flags;
	logic q_push;
	work_t q_push_data;
	logic q_pop;
	logic [WORK_W-1:0] q_head_bits;
	logic [QCW-1:0] q_count;
	logic clr_busy;
	logic hold;
	logic o_push;
	bundle_t o_push_data;
	logic [OCW-1:0] o_count;

	assign hold = clr_busy || (q_count == QCW'(QUEUE_DEPTH));

	trsc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.records(records),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.hold(hold),
		.flags(flags),
		.push(q_push),
		.push_data(q_push_data)
	);

	trsc_fifo #(
		.WIDTH(WORK_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.pop(q_pop),
		.head(q_head_bits),
		.count(q_count)
	);

	trsc_back #(
		.THREAD_ID_BITS(THREAD_ID_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.flags(flags),
		.q_empty(q_count == '0),
		.q_head(work_t'(q_head_bits)),
		.q_pop(q_pop),
		.out_count(o_count),
		.push(o_push),
		.push_data(o_push_data),
		.clr_busy(clr_busy)
	);

	trsc_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(o_push),
		.push_data(o_push_data),
		.count(o_count),
		.events(events)
	);

endmodule
`default_nettype wire

FILE: rtl/trsc_ram.sv
`default_nettype none
module trsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/trsc_fifo.sv
`default_nettype none
module trsc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] push_data,
	input wire logic pop,
	output logic [WIDTH-1:0] head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
		return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule
`default_nettype wire

FILE: rtl/trsc_front.sv
`default_nettype none
module trsc_front import trsc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	trsc_rec_if.sink records,
	input wire logic wr_en,
	input wire logic [CFG_INDEX_W-1:0] wr_index,
	input wire logic [CFG_DATA_W-1:0] wr_data,
	input wire logic hold,
	output flags_t flags,
	output logic push,
	output work_t push_data
);

	logic report_dup_q;
	logic report_ooo_q;
	logic [INDEX_W-1:0] start_q;
	logic [INDEX_W-1:0] end_q;
	logic [INDEX_W-1:0] rec_cnt_q;
	logic [INDEX_W-1:0] typed_cnt_q;
	logic [INDEX_W-1:0] meta_cnt_q;

	logic accept;
	logic in_win;
	kind_t kind;
	work_t work;

	assign records.ready = !hold;
	assign accept = records.valid && !hold;
	assign kind = kind_t'(records.record_kind);
	assign in_win = records.first_fragment && (rec_cnt_q >= start_q) && (rec_cnt_q <= end_q);

	always_comb begin
		work.typed = (kind == KIND_TYPED);
		work.idx = rec_cnt_q;
		work.tid = records.thread_id;
		work.pid = records.process_id;
		work.ts = records.timestamp;
		work.has_close = (kind != KIND_TYPED) && (typed_cnt_q != '0);
		work.close_cnt = typed_cnt_q;
		work.main_code = kind_event(kind);
		work.main_cnt = '0;
		case (kind)
			KIND_TYPED: begin
				work.has_main = 1'b0;
			end
			KIND_META_PAYLOAD: begin
				work.has_main = records.last_fragment;
				work.main_cnt = meta_cnt_q;
			end
			default: begin
				work.has_main = 1'b1;
			end
		endcase
	end

	assign push = accept && in_win && (work.typed || work.has_close || work.has_main);
	assign push_data = work;
	assign flags.report_dup = report_dup_q;
	assign flags.report_ooo = report_ooo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_dup_q <= 1'b0;
			report_ooo_q <= 1'b0;
			start_q <= '0;
			end_q <= '1;
			rec_cnt_q <= '0;
			typed_cnt_q <= '0;
			meta_cnt_q <= '0;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				CFG_REPORT_DUP: report_dup_q <= wr_data[0];
				CFG_REPORT_OOO: report_ooo_q <= wr_data[0];
				CFG_START_INDEX: begin
					start_q <= wr_data[INDEX_W-1:0];
					rec_cnt_q <= wr_data[INDEX_W-1:0];
				end
				CFG_END_INDEX: end_q <= wr_data[INDEX_W-1:0];
				default: ;
			endcase
		end else if (accept) begin
			rec_cnt_q <= rec_cnt_q + INDEX_W'(1);
			if (in_win) begin
				if (kind == KIND_TYPED) begin
					typed_cnt_q <= typed_cnt_q + INDEX_W'(1);
				end else begin
					typed_cnt_q <= '0;
				end
				if (kind == KIND_META_PAYLOAD && !records.last_fragment) begin
					meta_cnt_q <= meta_cnt_q + INDEX_W'(1);
				end else if (kind == KIND_META_HEADER) begin
					meta_cnt_q <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/trsc_back.sv
`default_nettype none
module trsc_back import trsc_pkg::*; #(
	parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire flags_t flags,
	input wire logic q_empty,
	input wire work_t q_head,
	output logic q_pop,
	input wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic push,
	output bundle_t push_data,
	output logic clr_busy
);

	localparam int AW = THREAD_ID_BITS;
	localparam int DEPTH = 2 ** THREAD_ID_BITS;

	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic v_s1;
	work_t work_s1;
	logic fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [ENTRY_W-1:0] fwd_data_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [AW-1:0] slot_s1;
	logic [ENTRY_W-1:0] prev;
	logic [TS_W-1:0] pts;
	logic [INDEX_W-1:0] pidx;
	logic ts_gt;
	logic ts_eq;
	logic upd;

	assign q_pop = !clr_busy_q && !q_empty && ((int'(out_count) + int'(v_s1)) < OUT_DEPTH);
	assign clr_busy = clr_busy_q;

	assign slot_s1 = work_s1.tid[AW-1:0];
	assign prev = (fwd_v_q && fwd_addr_q == slot_s1) ? fwd_data_q : ram_rdata;
	assign pts = prev[ENTRY_W-1:INDEX_W];
	assign pidx = prev[INDEX_W-1:0];
	assign ts_gt = work_s1.ts > pts;
	assign ts_eq = work_s1.ts == pts;
	assign upd = v_s1 && work_s1.typed && ts_gt;

	always_comb begin
		if (clr_busy_q) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we = upd;
			ram_waddr = slot_s1;
			ram_wdata = {work_s1.ts, work_s1.idx};
		end
	end

	trsc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(q_pop),
		.raddr(q_head.tid[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		push_data.idx = work_s1.idx;
		push_data.pid = work_s1.pid;
		push_data.ts = work_s1.ts;
		if (work_s1.typed) begin
			push_data.thread = work_s1.tid;
			push_data.has_close = 1'b0;
			push_data.close_cnt = '0;
			push_data.has_main = ts_eq ? flags.report_dup : (!ts_gt && flags.report_ooo);
			push_data.main_code = ts_eq ? EV_DUP : EV_OOO;
			push_data.pts = pts;
			push_data.pidx = pidx;
			push_data.main_cnt = '0;
		end else begin
			push_data.thread = '0;
			push_data.has_close = work_s1.has_close;
			push_data.close_cnt = work_s1.close_cnt;
			push_data.has_main = work_s1.has_main;
			push_data.main_code = work_s1.main_code;
			push_data.pts = '0;
			push_data.pidx = '0;
			push_data.main_cnt = work_s1.main_cnt;
		end
	end

	assign push = v_s1 && (push_data.has_close || push_data.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			v_s1 <= q_pop;
			if (upd) begin
				fwd_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_s1 <= q_head;
		end
		if (upd) begin
			fwd_addr_q <= slot_s1;
			fwd_data_q <= {work_s1.ts, work_s1.idx};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/trsc_out.sv
`default_nettype none
module trsc_out import trsc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bundle_t push_data,
	output logic [$clog2(OUT_DEPTH+1)-1:0] count,
	trsc_evt_if.source events
);

	bundle_t head;
	logic [BUNDLE_W-1:0] head_bits;
	logic sent_first_q;
	logic show_close;
	logic fire;
	logic pop;

	trsc_fifo #(
		.WIDTH(BUNDLE_W),
		.DEPTH(OUT_DEPTH)
	) u_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head(head_bits),
		.count(count)
	);

	assign head = bundle_t'(head_bits);
	assign show_close = head.has_close && !sent_first_q;
	assign events.valid = (count != '0);
	assign fire = events.valid && events.ready;
	assign pop = fire && !(show_close && head.has_main);

	assign events.event_res = show_close ? EV_CHUNK_END : head.main_code;
	assign events.record_index = head.idx;
	assign events.event_thread = show_close ? '0 : head.thread;
	assign events.event_process = head.pid;
	assign events.event_timestamp = head.ts;
	assign events.previous_timestamp = show_close ? '0 : head.pts;
	assign events.previous_index = show_close ? '0 : head.pidx;
	assign events.run_count = show_close ? head.close_cnt : head.main_cnt;
	assign events.last_of_run = !(show_close && head.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_first_q <= 1'b0;
		end else if (fire) begin
			sent_first_q <= show_close && head.has_main;
		end
	end

endmodule
`default_nettype wire

FILE: test/trace_record_stream_checker_tb.sv
`timescale 1ns / 1ps
module trace_record_stream_checker_tb import trsc_pkg::*;;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		kind_t kind;
		logic first;
		logic last;
		logic [15:0] tid;
		logic [15:0] pid;
		logic [63:0] ts;
	} rec_t;

	typedef struct {
		event_t code;
		logic [31:0] idx;
		logic [15:0] thread;
		logic [15:0] pid;
		logic [63:0] ts;
		logic [63:0] pts;
		logic [31:0] pidx;
		logic [31:0] cnt;
		logic last;
	} word_t;

	// A directed row either trusts the thread model or states its own outcome.
	typedef struct {
		kind_t kind;
		logic first;
		logic last;
		logic [15:0] tid;
		logic [15:0] pid;
		logic [63:0] ts;
		int fix_n;
		event_t fix_ev;
		logic [31:0] fix_cnt;
	} probe_t;

	localparam int BY_MODEL = -1;
	localparam int SETTLE_CYCLES = 8;
	localparam int N_PROBES = 22;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	cfg_index_t wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic evt_ready = 1'b0;

	idle_mode_t idle_mode = IDLE_NONE;
	int errors = 0;
	int words_checked = 0;
	int records_sent = 0;
	int records_kept = 0;
	logic [15:0] seen_events = '0;

	// Thread table and counters as the checker should hold them.
	bit [63:0] thr_time [65536];
	bit [31:0] thr_index [65536];
	logic [31:0] rec_ctr = '0;
	logic [31:0] typed_run = '0;
	logic [31:0] meta_count = '0;
	logic report_dup = 1'b0;
	logic report_ooo = 1'b0;
	logic [31:0] win_lo = '0;
	logic [31:0] win_hi = '1;

	word_t due_words[$];
	word_t next_words [2];
	bit in_window;
	logic [15:0] thread_pool [8];
	probe_t probes [N_PROBES];

	trsc_rec_if records();
	trsc_evt_if events();
	assign events.ready = evt_ready;

	trace_record_stream_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.records(records),
		.events(events),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #5 clk = ~clk;

	function automatic word_t event_word(input event_t code, input logic [31:0] idx,
		input logic [15:0] thread, input logic [15:0] pid, input logic [63:0] ts,
		input logic [63:0] pts, input logic [31:0] pidx, input logic [31:0] cnt);
		word_t w;
		w.code = code;
		w.idx = idx;
		w.thread = thread;
		w.pid = pid;
		w.ts = ts;
		w.pts = pts;
		w.pidx = pidx;
		w.cnt = cnt;
		w.last = 1'b0;
		return w;
	endfunction

	// Advances the thread state by one accepted record and stages its event words.
	function automatic int classify_record(input rec_t r);
		logic [31:0] idx;
		logic [63:0] pts;
		logic [31:0] pidx;
		event_t own_code;
		logic [31:0] own_cnt;
		bit emit_own;
		int n;
		n = 0;
		idx = rec_ctr;
		rec_ctr = rec_ctr + 1;
		in_window = (idx >= win_lo) && (idx <= win_hi) && r.first;
		if (!in_window)
			return 0;
		if (r.kind == KIND_TYPED) begin
			pts = thr_time[r.tid];
			pidx = thr_index[r.tid];
			if (r.ts > pts) begin
				thr_time[r.tid] = r.ts;
				thr_index[r.tid] = idx;
			end else if (r.ts == pts) begin
				if (report_dup) begin
					next_words[n] = event_word(EV_DUP, idx, r.tid, r.pid, r.ts, pts, pidx, '0);
					n = n + 1;
				end
			end else if (report_ooo) begin
				next_words[n] = event_word(EV_OOO, idx, r.tid, r.pid, r.ts, pts, pidx, '0);
				n = n + 1;
			end
			typed_run = typed_run + 1;
		end else begin
			if (typed_run != 0) begin
				next_words[n] = event_word(EV_CHUNK_END, idx, '0, r.pid, r.ts, '0, '0, typed_run);
				n = n + 1;
			end
			typed_run = '0;
			own_cnt = '0;
			emit_own = 1'b1;
			case (r.kind)
				KIND_META_PAYLOAD: begin
					own_code = EV_META_END;
					own_cnt = meta_count;
					emit_own = r.last;
					if (!r.last)
						meta_count = meta_count + 1;
				end
				KIND_META_HEADER: begin
					own_code = EV_META_START;
					meta_count = '0;
				end
				KIND_DUMP_HEADER: own_code = EV_DUMP;
				KIND_CHUNK: own_code = EV_CHUNK;
				KIND_FILE_HEADER: own_code = EV_FILE_START;
				KIND_EOF: own_code = EV_EOF;
				default: own_code = EV_UNKNOWN;
			endcase
			if (emit_own) begin
				next_words[n] = event_word(own_code, idx, '0, r.pid, r.ts, '0, '0, own_cnt);
				n = n + 1;
			end
		end
		if (n > 0)
			next_words[n-1].last = 1'b1;
		return n;
	endfunction

	function automatic rec_t random_record();
		rec_t r;
		int pick;
		logic [63:0] prev;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			r.kind = KIND_TYPED;
		else if (pick < 67)
			r.kind = KIND_META_PAYLOAD;
		else if (pick < 75)
			r.kind = KIND_META_HEADER;
		else
			r.kind = kind_t'($urandom_range(KIND_DUMP_HEADER, KIND_OTHER));
		r.first = $urandom_range(0, 99) < 90;
		r.last = 1'($urandom_range(0, 1));
		r.tid = ($urandom_range(0, 99) < 80) ? thread_pool[$urandom_range(0, 7)] : 16'($urandom);
		r.pid = 16'($urandom);
		r.ts = {$urandom, $urandom};
		if (r.kind == KIND_TYPED) begin
			prev = thr_time[r.tid];
			pick = $urandom_range(0, 99);
			if (pick < 35)
				r.ts = prev + 64'($urandom_range(1, 1000));
			else if (pick < 60)
				r.ts = prev;
			else if (pick < 85)
				r.ts = prev - 64'($urandom_range(1, 1000));
		end
		return r;
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 59;
			IDLE_BOTH: return $urandom_range(0, 99) < 32;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(0, 99) < 59;
			IDLE_BOTH: return $urandom_range(0, 99) < 32;
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_record(input rec_t r);
		while (sender_gap()) begin
			records.valid <= 1'b0;
			@(posedge clk);
		end
		records.valid <= 1'b1;
		records.record_kind <= r.kind;
		records.first_fragment <= r.first;
		records.last_fragment <= r.last;
		records.thread_id <= r.tid;
		records.process_id <= r.pid;
		records.timestamp <= r.ts;
		do
			@(posedge clk);
		while (!records.ready);
		records_sent++;
	endtask

	task automatic write_reg(input cfg_index_t which, input logic [31:0] value);
		wr_en <= 1'b1;
		wr_index <= which;
		wr_data <= value;
		@(posedge clk);
		case (which)
			CFG_REPORT_DUP: report_dup = value[0];
			CFG_REPORT_OOO: report_ooo = value[0];
			CFG_START_INDEX: begin
				win_lo = value;
				rec_ctr = value;
			end
			CFG_END_INDEX: win_hi = value;
			default: ;
		endcase
	endtask

	task automatic settle();
		records.valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic expect_staged(input int n);
		for (int k = 0; k < n; k++)
			due_words.push_back(next_words[k]);
	endtask

	task automatic run_phase(input logic dup, input logic ooo, input logic [31:0] lo,
		input logic [31:0] hi, input idle_mode_t mode, input int goal, input bit pause_mid);
		int looked;
		int sent;
		int n;
		bit paused;
		rec_t r;
		write_reg(CFG_REPORT_DUP, 32'(dup));
		write_reg(CFG_REPORT_OOO, 32'(ooo));
		write_reg(CFG_START_INDEX, lo);
		write_reg(CFG_END_INDEX, hi);
		wr_en <= 1'b0;
		idle_mode = mode;
		looked = 0;
		sent = 0;
		paused = 1'b0;
		while (looked < goal && sent < goal + goal / 2) begin
			if (pause_mid && !paused && looked >= goal / 2) begin
				settle();
				paused = 1'b1;
			end
			r = random_record();
			send_record(r);
			n = classify_record(r);
			expect_staged(n);
			sent++;
			if (in_window) begin
				looked++;
				records_kept++;
			end
		end
		settle();
		idle_mode = IDLE_NONE;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		word_t want;
		if (!arst_n) begin
			evt_ready <= 1'b0;
		end else begin
			if (events.valid && evt_ready) begin
				if (due_words.size() == 0) begin
					$error("event word with nothing pending: event_res %0d, record_index %0d",
						events.event_res, events.record_index);
					errors++;
				end else begin
					want = due_words.pop_front();
					check_field("event_res", 64'(want.code), 64'(events.event_res));
					check_field("record_index", 64'(want.idx), 64'(events.record_index));
					check_field("event_thread", 64'(want.thread), 64'(events.event_thread));
					check_field("event_process", 64'(want.pid), 64'(events.event_process));
					check_field("event_timestamp", want.ts, events.event_timestamp);
					check_field("previous_timestamp", want.pts, events.previous_timestamp);
					check_field("previous_index", 64'(want.pidx), 64'(events.previous_index));
					check_field("run_count", 64'(want.cnt), 64'(events.run_count));
					check_field("last_of_run", 64'(want.last), 64'(events.last_of_run));
					words_checked++;
					seen_events[events.event_res] = 1'b1;
				end
			end
			evt_ready <= !receiver_stall();
		end
	end

	initial begin
		int n;
		logic [31:0] base_idx;
		rec_t r;
		records.valid <= 1'b0;
		records.record_kind <= KIND_TYPED;
		records.first_fragment <= 1'b0;
		records.last_fragment <= 1'b0;
		records.thread_id <= '0;
		records.process_id <= '0;
		records.timestamp <= '0;
		wr_en <= 1'b0;
		wr_index <= CFG_REPORT_DUP;
		wr_data <= '0;
		thread_pool[0] = 16'h0000;
		thread_pool[1] = 16'hFFFF;
		for (int k = 2; k < 8; k++)
			thread_pool[k] = 16'($urandom);
		probes = '{
			'{KIND_FILE_HEADER, 1'b1, 1'b0, 16'h0000, 16'h0000, 64'h0, 1, EV_FILE_START, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'h0000, 16'h0001, 64'h0, BY_MODEL, EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'hFFFF, 16'h0002, 64'h5, BY_MODEL, EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'hFFFF, 16'h0003, 64'hFFFF_FFFF_FFFF_FFFF, BY_MODEL,
				EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b0, 1'b1, 16'h1234, 16'h0004, 64'h0, 0, EV_DUP, 32'd0},
			'{KIND_CHUNK, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 64'h77, BY_MODEL, EV_DUP, 32'd0},
			'{KIND_META_HEADER, 1'b1, 1'b0, 16'h0000, 16'h0010, 64'h80, 1, EV_META_START, 32'd0},
			'{KIND_META_PAYLOAD, 1'b1, 1'b0, 16'h0000, 16'h0011, 64'h81, 0, EV_DUP, 32'd0},
			'{KIND_META_PAYLOAD, 1'b1, 1'b0, 16'h0000, 16'h0012, 64'h82, 0, EV_DUP, 32'd0},
			'{KIND_META_PAYLOAD, 1'b1, 1'b1, 16'h0000, 16'h0013, 64'h83, 1, EV_META_END, 32'd2},
			'{KIND_META_PAYLOAD, 1'b1, 1'b1, 16'h0000, 16'h0014, 64'h84, 1, EV_META_END, 32'd2},
			'{KIND_DUMP_HEADER, 1'b1, 1'b0, 16'h0000, 16'h0015, 64'h85, 1, EV_DUMP, 32'd0},
			'{KIND_EOF, 1'b1, 1'b0, 16'h0000, 16'h0016, 64'h86, 1, EV_EOF, 32'd0},
			'{KIND_OTHER, 1'b1, 1'b0, 16'h0000, 16'h0017, 64'h87, 1, EV_UNKNOWN, 32'd0},
			'{KIND_OTHER, 1'b0, 1'b1, 16'h0000, 16'h0018, 64'h88, 0, EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'h0000, 16'h0019, 64'h1, 0, EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'h0000, 16'h001A, 64'h1, BY_MODEL, EV_DUP, 32'd0},
			'{KIND_META_HEADER, 1'b1, 1'b0, 16'h0000, 16'h001B, 64'h90, BY_MODEL, EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'h8000, 16'hAAAA, 64'h8000_0000_0000_0000, 0,
				EV_DUP, 32'd0},
			'{KIND_TYPED, 1'b1, 1'b0, 16'h7FFF, 16'h5555, 64'h0, BY_MODEL, EV_DUP, 32'd0},
			'{KIND_EOF, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, BY_MODEL,
				EV_DUP, 32'd0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_REPORT_DUP, 32'd1);
		write_reg(CFG_REPORT_OOO, 32'd1);
		wr_en <= 1'b0;
		foreach (probes[i]) begin
			r.kind = probes[i].kind;
			r.first = probes[i].first;
			r.last = probes[i].last;
			r.tid = probes[i].tid;
			r.pid = probes[i].pid;
			r.ts = probes[i].ts;
			base_idx = rec_ctr;
			send_record(r);
			n = classify_record(r);
			if (in_window)
				records_kept++;
			if (probes[i].fix_n == BY_MODEL) begin
				expect_staged(n);
			end else if (probes[i].fix_n == 1) begin
				next_words[0] = event_word(probes[i].fix_ev, base_idx, '0, r.pid, r.ts, '0, '0,
					probes[i].fix_cnt);
				next_words[0].last = 1'b1;
				expect_staged(1);
			end
		end
		settle();

		run_phase(1'b1, 1'b1, 32'h0, 32'hFFFF_FFFF, IDLE_NONE, 90, 1'b0);
		run_phase(1'b0, 1'b1, 32'd1000, 32'd1049, IDLE_SENDER, 60, 1'b0);
		run_phase(1'b1, 1'b0, 32'hFFFF_FFC0, 32'hFFFF_FFFF, IDLE_RECEIVER, 80, 1'b0);
		run_phase(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_BOTH, 8, 1'b0);
		run_phase(1'b1, 1'b1, 32'h0, 32'h0, IDLE_SENDER, 8, 1'b0);
		run_phase(1'b1, 1'b1, 32'd7, 32'hFFFF_FFFF, IDLE_BOTH, 110, 1'b1);
		run_phase(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, IDLE_RECEIVER, 60, 1'b0);

		if (due_words.size() != 0)
			$error("%0d expected event words never arrived", due_words.size());
		$display("Run covered %0d records, %0d of them inside the window as first fragments,",
			records_sent, records_kept);
		$display("and checked %0d event words covering %0d of the 10 event codes.",
			words_checked, $countones(seen_events[9:0]));
		if (errors == 0 && due_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
